// File: hdl/rmc_pkg.sv
// Shared constants, types and helpers for the range-match CAM search block.
package rmc_pkg;

  // Array geometry
  localparam int unsigned ROWS       = 256;
  localparam int unsigned COLUMNS    = 32;
  localparam int unsigned VALUE_BITS = 8;

  // One cell of the chain covers one 64-row word
  localparam int unsigned LANES  = 64;
  localparam int unsigned LANE_W = $clog2(LANES);
  localparam int unsigned WORDS  = (ROWS + LANES - 1) / LANES;
  localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned COL_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Port field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 5;
  localparam int unsigned BOUND_W = 8;
  localparam int unsigned EIDX_W  = 2;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned OIDX_W  = 2;

  // Width used to compare a word select against a cell index
  localparam int unsigned RSEL_HI = ROW_W - LANE_W;
  localparam int unsigned RSEL_W  = (WIDX_W > RSEL_HI) ?
                                    ((WIDX_W > EIDX_W) ? WIDX_W : EIDX_W) :
                                    ((RSEL_HI > EIDX_W) ? RSEL_HI : EIDX_W);
  localparam int unsigned VB_EXT_W = (VALUE_BITS > BOUND_W) ? VALUE_BITS : BOUND_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PROGRAM = 2'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;

  // One stored threshold cell
  typedef struct packed {
    value_t lo;
    value_t hi;
    logic   lo_open;
    logic   hi_open;
  } thr_t;

  // Item travelling down the chain, with the match words gathered so far
  typedef struct packed {
    logic [OP_W-1:0]               op;
    logic [ROW_W-1:0]              row;
    logic [COL_W-1:0]              col;
    logic [BOUND_W-1:0]            lo;
    logic [BOUND_W-1:0]            hi;
    logic                          lo_open;
    logic                          hi_open;
    logic [EIDX_W-1:0]             en_idx;
    logic [MASK_W-1:0]             mask;
    logic [BOUND_W-1:0]            qval;
    logic                          wild;
    logic                          last;
    logic [WORDS-1:0][LANES-1:0]   words;
  } tok_t;

  // Low VALUE_BITS bits of an 8-bit field, zero-extended where wider
  function automatic value_t to_value(input logic [BOUND_W-1:0] x);
    logic [VB_EXT_W-1:0] e;
    e = VB_EXT_W'(x);
    return e[VALUE_BITS-1:0];
  endfunction

endpackage

// File: hdl/rmc_cell.sv
// One chain cell: thresholds, enables and match bits of one 64-row word.
module rmc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [rmc_pkg::WIDX_W-1:0]    idx_i,
  input  logic                          in_vld_i,
  input  rmc_pkg::tok_t                 in_tok_i,
  output logic                          out_vld_o,
  output rmc_pkg::tok_t                 out_tok_o
);

  logic [rmc_pkg::LANES-1:0]   lane_ok;

  // stage A: memory access
  logic                        sel_a;
  logic [rmc_pkg::LANE_W-1:0]  lane_a;
  logic                        col_ok_a;
  logic [rmc_pkg::COL_AW-1:0]  addr_a;
  logic                        wr_a;
  logic                        rd_a;
  rmc_pkg::thr_t               wdata_a;

  rmc_pkg::thr_t [rmc_pkg::LANES-1:0] mem_q [rmc_pkg::COLUMNS];
  rmc_pkg::thr_t [rmc_pkg::LANES-1:0] rd_q;

  logic                        a_vld_q;
  rmc_pkg::tok_t               a_tok_q;

  // stage B: compare and accumulate
  rmc_pkg::value_t             v_b;
  logic [rmc_pkg::LANES-1:0]   hit_b;
  logic                        q_on_b;
  logic                        col_ok_b;
  logic                        en_wr_b;
  logic [rmc_pkg::LANES-1:0]   acc_upd;
  logic [rmc_pkg::LANES-1:0]   acc_d, acc_q;
  logic [rmc_pkg::LANES-1:0]   en_d, en_q;
  rmc_pkg::tok_t               b_tok_d, b_tok_q;
  logic                        b_vld_q;

  // lanes that map to real rows
  always_comb begin
    for (int l = 0; l < rmc_pkg::LANES; l++) begin
      lane_ok[l] = ((32'(idx_i) << rmc_pkg::LANE_W) + 32'(l)) < 32'(rmc_pkg::ROWS);
    end
  end

  always_comb begin
    sel_a    = rmc_pkg::RSEL_W'(in_tok_i.row >> rmc_pkg::LANE_W) ==
               rmc_pkg::RSEL_W'(idx_i);
    lane_a   = in_tok_i.row[rmc_pkg::LANE_W-1:0];
    col_ok_a = 32'(in_tok_i.col) < 32'(rmc_pkg::COLUMNS);
    addr_a   = rmc_pkg::COL_AW'(in_tok_i.col);
    wr_a     = adv_i && in_vld_i && (in_tok_i.op == rmc_pkg::OP_PROGRAM) &&
               sel_a && lane_ok[lane_a] && col_ok_a;
    rd_a     = adv_i && in_vld_i && (in_tok_i.op == rmc_pkg::OP_QUERY) && col_ok_a;
    wdata_a.lo      = rmc_pkg::to_value(in_tok_i.lo);
    wdata_a.hi      = rmc_pkg::to_value(in_tok_i.hi);
    wdata_a.lo_open = in_tok_i.lo_open;
    wdata_a.hi_open = in_tok_i.hi_open;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_q[addr_a][lane_a] <= wdata_a;
    end
    if (rd_a) begin
      rd_q <= mem_q[addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_tok_q <= in_tok_i;
      b_tok_q <= b_tok_d;
    end
  end

  always_comb begin
    v_b      = rmc_pkg::to_value(a_tok_q.qval);
    q_on_b   = a_vld_q && (a_tok_q.op == rmc_pkg::OP_QUERY);
    col_ok_b = 32'(a_tok_q.col) < 32'(rmc_pkg::COLUMNS);
    en_wr_b  = a_vld_q && (a_tok_q.op == rmc_pkg::OP_ENABLE) &&
               (rmc_pkg::RSEL_W'(a_tok_q.en_idx) == rmc_pkg::RSEL_W'(idx_i));
    for (int l = 0; l < rmc_pkg::LANES; l++) begin
      hit_b[l] = a_tok_q.wild ||
                 ((rd_q[l].lo_open || (rd_q[l].lo <= v_b)) &&
                  (rd_q[l].hi_open || (v_b < rd_q[l].hi)));
    end
    acc_upd = (q_on_b && col_ok_b) ? (acc_q & hit_b) : acc_q;
    acc_d   = (q_on_b && a_tok_q.last) ? '1 : acc_upd;
    en_d    = en_wr_b ? (a_tok_q.mask & lane_ok) : en_q;
    b_tok_d = a_tok_q;
    if (q_on_b && a_tok_q.last) begin
      b_tok_d.words[idx_i] = acc_upd & en_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      acc_q   <= '1;
      en_q    <= '0;
    end else if (adv_i) begin
      a_vld_q <= in_vld_i;
      b_vld_q <= a_vld_q;
      acc_q   <= acc_d;
      en_q    <= en_d;
    end
  end

  assign out_vld_o = b_vld_q;
  assign out_tok_o = b_tok_q;

endmodule

// File: hdl/rmc_emit.sv
// Result serialiser: holds a finished query's words and sends one per transfer.
module rmc_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tail_vld_i,
  input  rmc_pkg::tok_t                 tail_tok_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rmc_pkg::OIDX_W-1:0]    match_word_index_o,
  output logic [rmc_pkg::MASK_W-1:0]    match_bits_o,
  output logic                          last_word_o
);

  logic                                    emit;
  logic                                    load;
  logic                                    xfer;
  logic                                    busy_q;
  logic [rmc_pkg::WIDX_W-1:0]              cnt_q;
  logic [rmc_pkg::WORDS-1:0][rmc_pkg::LANES-1:0] words_q;

  assign emit  = tail_vld_i && (tail_tok_i.op == rmc_pkg::OP_QUERY) && tail_tok_i.last;
  assign adv_o = !(emit && busy_q);
  assign load  = emit && !busy_q;
  assign xfer  = busy_q && !out_stall_i;

  assign out_valid_o        = busy_q;
  assign match_word_index_o = rmc_pkg::OIDX_W'(cnt_q);
  assign match_bits_o       = rmc_pkg::MASK_W'(words_q[0]);
  assign last_word_o        = cnt_q == rmc_pkg::WIDX_W'(rmc_pkg::WORDS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (xfer) begin
      if (last_word_o) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // words shift down so the current one always sits at the bottom
  always_ff @(posedge clk_i) begin
    if (load) begin
      words_q <= tail_tok_i.words;
    end else if (xfer) begin
      for (int i = 0; i < rmc_pkg::WORDS - 1; i++) begin
        words_q[i] <= words_q[i+1];
      end
    end
  end

endmodule

// File: hdl/range_match_cam_search.sv
// Range-match CAM search: chain of word cells followed by the result serialiser.
//
// Usage notes
//   Input channel (in_valid_i / in_stall_o) carries program, enable and query
//   items; one item per transfer. Output channel (out_valid_o / out_stall_i)
//   carries match words, one 64-row word per transfer, WORDS per finished query.
//   The item walks a chain of WORDS cells, two registers per cell: memory
//   read, then compare and accumulate. The whole chain steps as one unless held.
//   Throughput: one item per cycle unless held. A last-column query reaching
//   the chain end while the previous result is still being sent holds the
//   chain (and in_stall_o) until the final word of that result has been taken.
//   A query's result is loaded into the serialiser once its last-column
//   item has passed both registers of every cell; the words then leave one
//   per cycle while out_stall_i is low.
//   Reset clears enables to zero and arms all match bits; threshold cells hold
//   nothing useful until programmed. With out_stall_i high the current word is
//   held steady until taken.
module range_match_cam_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rmc_pkg::OP_W-1:0]       operation_i,
  input  logic [rmc_pkg::ROW_W-1:0]      row_i,
  input  logic [rmc_pkg::COL_W-1:0]      column_i,
  input  logic [rmc_pkg::BOUND_W-1:0]    low_bound_i,
  input  logic [rmc_pkg::BOUND_W-1:0]    high_bound_i,
  input  logic                           low_unbounded_i,
  input  logic                           high_unbounded_i,
  input  logic [rmc_pkg::EIDX_W-1:0]     enable_word_index_i,
  input  logic [rmc_pkg::MASK_W-1:0]     enable_mask_i,
  input  logic [rmc_pkg::BOUND_W-1:0]    query_value_i,
  input  logic                           query_wildcard_i,
  input  logic                           last_column_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rmc_pkg::OIDX_W-1:0]     match_word_index_o,
  output logic [rmc_pkg::MASK_W-1:0]     match_bits_o,
  output logic                           last_word_o
);

  // global chain step; low only when the serialiser cannot take a result
  logic                  adv;
  logic                  vld [rmc_pkg::WORDS+1];
  rmc_pkg::tok_t         tok [rmc_pkg::WORDS+1];

  assign in_stall_o = !adv;

  // pack the input transfer into a chain item
  always_comb begin
    tok[0]         = '0;
    tok[0].op      = operation_i;
    tok[0].row     = row_i;
    tok[0].col     = column_i;
    tok[0].lo      = low_bound_i;
    tok[0].hi      = high_bound_i;
    tok[0].lo_open = low_unbounded_i;
    tok[0].hi_open = high_unbounded_i;
    tok[0].en_idx  = enable_word_index_i;
    tok[0].mask    = enable_mask_i;
    tok[0].qval    = query_value_i;
    tok[0].wild    = query_wildcard_i;
    tok[0].last    = last_column_i;
  end
  assign vld[0] = in_valid_i;

  // one cell per 64-row word, each handing the item to the next
  for (genvar g = 0; g < rmc_pkg::WORDS; g++) begin : g_cell
    rmc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .idx_i     (rmc_pkg::WIDX_W'(g)),
      .in_vld_i  (vld[g]),
      .in_tok_i  (tok[g]),
      .out_vld_o (vld[g+1]),
      .out_tok_o (tok[g+1])
    );
  end

  rmc_emit u_emit (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tail_vld_i         (vld[rmc_pkg::WORDS]),
    .tail_tok_i         (tok[rmc_pkg::WORDS]),
    .adv_o              (adv),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .match_word_index_o (match_word_index_o),
    .match_bits_o       (match_bits_o),
    .last_word_o        (last_word_o)
  );

  // a result always starts at word zero
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> match_word_index_o == '0)
    else $error("result did not start at word zero");

  // words of one result come in order
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=>
      (out_valid_o && (match_word_index_o ==
        rmc_pkg::OIDX_W'($past(match_word_index_o) + 1'b1))))
    else $error("match word skipped or repeated");

  // a gap follows the final word of a result
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> !out_valid_o)
    else $error("next result began without a gap");

endmodule

// File: dv/tb.sv
// Self-checking testbench for range_match_cam_search: shadow array, random traffic, word checks.
`timescale 1ns / 1ps

import rmc_pkg::*;

// One input transfer, every field kept even where the operation ignores it
typedef struct {
  logic [OP_W-1:0]    op;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [BOUND_W-1:0] lo;
  logic [BOUND_W-1:0] hi;
  logic               lo_open;
  logic               hi_open;
  logic [EIDX_W-1:0]  eidx;
  logic [MASK_W-1:0]  mask;
  logic [BOUND_W-1:0] qval;
  logic               wild;
  logic               last;
} cam_item_t;

// One match word as it should leave the block
typedef struct {
  logic [OIDX_W-1:0] idx;
  logic [MASK_W-1:0] bits;
  logic              last;
} match_word_t;

// Shadow copy of the CAM: cells, row enables and per-row hit bits
class cam_shadow;
  thr_t             cell_store [ROWS*COLUMNS];
  logic [MASK_W-1:0] enable_words [WORDS];
  bit               row_hits [ROWS];
  match_word_t      match_words_due [$];
  int               errors;

  function new();
    foreach (enable_words[w]) enable_words[w] = '0;
    foreach (row_hits[r]) row_hits[r] = 1'b1;
    errors = 0;
  endfunction

  function bit cell_matches(thr_t c, value_t v, logic wild);
    return wild || ((c.lo_open || c.lo <= v) && (c.hi_open || v < c.hi));
  endfunction

  // Update the shadow with an accepted transfer; queue match words on a last column
  function void apply_item(cam_item_t it);
    thr_t              c;
    value_t            v;
    logic [MASK_W-1:0] bits;
    match_word_t       mw;
    int                idx;
    case (it.op)
      OP_PROGRAM: begin
        if (int'(it.row) < ROWS && int'(it.col) < COLUMNS) begin
          c.lo      = value_t'(it.lo);
          c.hi      = value_t'(it.hi);
          c.lo_open = it.lo_open;
          c.hi_open = it.hi_open;
          idx = int'(it.row) * COLUMNS + int'(it.col);
          cell_store[idx] = c;
        end
      end
      OP_ENABLE: begin
        if (int'(it.eidx) < WORDS) begin
          for (int i = 0; i < LANES; i++)
            enable_words[it.eidx][i] = it.mask[i] && (int'(it.eidx) * LANES + i < ROWS);
        end
      end
      OP_QUERY: begin
        v = value_t'(it.qval);
        if (int'(it.col) < COLUMNS) begin
          for (int r = 0; r < ROWS; r++)
            if (!cell_matches(cell_store[r * COLUMNS + int'(it.col)], v, it.wild))
              row_hits[r] = 1'b0;
        end
        if (it.last) begin
          for (int w = 0; w < WORDS; w++) begin
            bits = '0;
            for (int i = 0; i < LANES; i++)
              if (w * LANES + i < ROWS && row_hits[w * LANES + i]) bits[i] = 1'b1;
            mw.idx  = OIDX_W'(w);
            mw.bits = bits & enable_words[w];
            mw.last = (w == WORDS - 1);
            match_words_due.push_back(mw);
          end
          foreach (row_hits[r]) row_hits[r] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task check_match_word(logic [OIDX_W-1:0] idx, logic [MASK_W-1:0] bits, logic last);
    match_word_t due;
    if (match_words_due.size() == 0) begin
      report($sformatf("match word %0d (%h) with nothing due", idx, bits));
      return;
    end
    due = match_words_due.pop_front();
    if (idx !== due.idx)
      report($sformatf("word index got %0d want %0d", idx, due.idx));
    if (bits !== due.bits)
      report($sformatf("word %0d bits got %h want %h", due.idx, bits, due.bits));
    if (last !== due.last)
      report($sformatf("word %0d last flag got %b want %b", due.idx, last, due.last));
  endtask
endclass

module tb;

  // Operation code the block has no use for
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The one column that is filled in every row; all queries read only this one,
  // program transfers still land anywhere in the array
  localparam logic [COL_W-1:0] QCOL = 5'd21;

  localparam int RANDOM_ITEMS = 220;
  localparam int LONG_HOLD    = 400;
  // Extra wait once all words are in, sized from the chain length; allow plenty more
  localparam int DRAIN_CYCLES = 4 * (2 * WORDS + 1) + 16;
  // Run limit with a wide margin over the worst case (every item closing a query
  // under heavy receiver stall)
  localparam int CYCLE_LIMIT  = 100_000;

  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               in_valid_i          = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    operation_i         = '0;
  logic [ROW_W-1:0]   row_i               = '0;
  logic [COL_W-1:0]   column_i            = '0;
  logic [BOUND_W-1:0] low_bound_i         = '0;
  logic [BOUND_W-1:0] high_bound_i        = '0;
  logic               low_unbounded_i     = 1'b0;
  logic               high_unbounded_i    = 1'b0;
  logic [EIDX_W-1:0]  enable_word_index_i = '0;
  logic [MASK_W-1:0]  enable_mask_i       = '0;
  logic [BOUND_W-1:0] query_value_i       = '0;
  logic               query_wildcard_i    = 1'b0;
  logic               last_column_i       = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i         = 1'b0;
  logic [OIDX_W-1:0]  match_word_index_o;
  logic [MASK_W-1:0]  match_bits_o;
  logic               last_word_o;

  cam_shadow shadow;
  int        burst_left     = 0;  // transfers left in the current sender burst
  int        items_accepted = 0;  // accepted transfers the block acts upon
  int        cycle_count    = 0;
  bit        hold_request   = 1'b0;

  range_match_cam_search u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .row_i               (row_i),
    .column_i            (column_i),
    .low_bound_i         (low_bound_i),
    .high_bound_i        (high_bound_i),
    .low_unbounded_i     (low_unbounded_i),
    .high_unbounded_i    (high_unbounded_i),
    .enable_word_index_i (enable_word_index_i),
    .enable_mask_i       (enable_mask_i),
    .query_value_i       (query_value_i),
    .query_wildcard_i    (query_wildcard_i),
    .last_column_i       (last_column_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .match_word_index_o  (match_word_index_o),
    .match_bits_o        (match_bits_o),
    .last_word_o         (last_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Timeout: a hang or a lost match word ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Item builders. Fields the operation ignores are left random on purpose.
  // ---------------------------------------------------------------------------
  function automatic cam_item_t noise_item();
    cam_item_t it;
    it.op      = OP_W'($urandom_range(0, 3));
    it.row     = ROW_W'($urandom);
    it.col     = COL_W'($urandom);
    it.lo      = BOUND_W'($urandom);
    it.hi      = BOUND_W'($urandom);
    it.lo_open = 1'($urandom);
    it.hi_open = 1'($urandom);
    it.eidx    = EIDX_W'($urandom);
    it.mask    = {$urandom, $urandom};
    it.qval    = BOUND_W'($urandom);
    it.wild    = 1'($urandom);
    it.last    = 1'($urandom);
    return it;
  endfunction

  function automatic cam_item_t program_item(input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c,
                                             input logic [BOUND_W-1:0] lo,
                                             input logic [BOUND_W-1:0] hi,
                                             input logic lo_open,
                                             input logic hi_open);
    cam_item_t it;
    it         = noise_item();
    it.op      = OP_PROGRAM;
    it.row     = r;
    it.col     = c;
    it.lo      = lo;
    it.hi      = hi;
    it.lo_open = lo_open;
    it.hi_open = hi_open;
    return it;
  endfunction

  function automatic cam_item_t enable_item(input logic [EIDX_W-1:0] w,
                                            input logic [MASK_W-1:0] mask);
    cam_item_t it;
    it      = noise_item();
    it.op   = OP_ENABLE;
    it.eidx = w;
    it.mask = mask;
    return it;
  endfunction

  function automatic cam_item_t query_item(input logic [COL_W-1:0] c,
                                          input logic [BOUND_W-1:0] v,
                                          input logic wild,
                                          input logic last);
    cam_item_t it;
    it      = noise_item();
    it.op   = OP_QUERY;
    it.col  = c;
    it.qval = v;
    it.wild = wild;
    it.last = last;
    return it;
  endfunction

  // Mostly wide ranges so that queries leave a fair share of rows matching;
  // one cell in ten gets fully random bounds (empty and inverted ranges too).
  function automatic cam_item_t random_program(input int r, input int c);
    if ($urandom_range(0, 9) == 0)
      return program_item(ROW_W'(r), COL_W'(c), BOUND_W'($urandom), BOUND_W'($urandom),
                          1'($urandom), 1'($urandom));
    return program_item(ROW_W'(r), COL_W'(c), BOUND_W'($urandom_range(0, 100)),
                        BOUND_W'($urandom_range(150, 255)),
                        $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0, 1:    return '1;
      2:       return '0;
      3:       return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. Each call
  // returns at the edge where the transfer was accepted.
  // ---------------------------------------------------------------------------
  task automatic send_item(input cam_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // a quarter of the bursts follow straight on, giving gap-free stretches
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    operation_i         <= it.op;
    row_i               <= it.row;
    column_i            <= it.col;
    low_bound_i         <= it.lo;
    high_bound_i        <= it.hi;
    low_unbounded_i     <= it.lo_open;
    high_unbounded_i    <= it.hi_open;
    enable_word_index_i <= it.eidx;
    enable_mask_i       <= it.mask;
    query_value_i       <= it.qval;
    query_wildcard_i    <= it.wild;
    last_column_i       <= it.last;
    in_valid_i          <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    shadow.apply_item(it);
    if (it.op != OP_UNUSED) items_accepted++;
  endtask

  // A whole query of ncols columns. Now and then a program or enable transfer
  // is slipped in between columns: the match bits must carry across it.
  task automatic send_query(input int ncols);
    logic [BOUND_W-1:0] v;
    for (int k = 0; k < ncols; k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_item(random_program($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1)));
        else
          send_item(enable_item(EIDX_W'($urandom), random_mask()));
      end
      // mid values sit inside most programmed ranges; the rest span the full scale
      v = ($urandom_range(0, 9) < 7) ? BOUND_W'($urandom_range(100, 150)) : BOUND_W'($urandom);
      send_item(query_item(QCOL, v, $urandom_range(0, 4) == 0, k == ncols - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks every accepted match word, stalls in segments of random
  // duty, and once holds off for a long stretch so the chain fills and the
  // input side backs up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int seg_left;
    int stall_pct;
    int hold_left;
    bit hold_done;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        shadow.check_match_word(match_word_index_o, match_bits_o, last_word_o);
      if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 160);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int random_start;
    int ncols;
    shadow = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every row of the query column first: a query column reads all rows,
    // and no cell may be read before it has been written.
    for (int r = 0; r < ROWS; r++)
      send_item(random_program(r, QCOL));

    // Enables are still at their reset value: all match words come out zero
    send_item(query_item(QCOL, 8'd120, 1'b0, 1'b1));
    for (int w = 0; w < WORDS; w++)
      send_item(enable_item(EIDX_W'(w), '1));
    // Wildcard column matches every row
    send_item(query_item(QCOL, 8'd0, 1'b1, 1'b1));

    // Bound extremes: full closed range, both sides open, empty range, top value only
    send_item(program_item(8'd0, QCOL, 8'd0, 8'd255, 1'b0, 1'b0));
    send_item(program_item(8'd255, QCOL, 8'd255, 8'd0, 1'b1, 1'b1));
    send_item(program_item(8'd1, QCOL, 8'd255, 8'd255, 1'b0, 1'b0));
    send_item(program_item(8'd2, QCOL, 8'd255, 8'd0, 1'b0, 1'b1));
    send_item(query_item(QCOL, 8'd0, 1'b0, 1'b1));
    send_item(query_item(QCOL, 8'd255, 1'b0, 1'b1));
    // Two-transfer query on the same column ANDs both transfers
    send_item(query_item(QCOL, 8'd255, 1'b0, 1'b0));
    send_item(query_item(QCOL, 8'd128, 1'b0, 1'b1));

    // Unused operation code: no effect, no result
    begin
      cam_item_t junk;
      junk    = noise_item();
      junk.op = OP_UNUSED;
      send_item(junk);
    end

    // Partial and empty enable words mask the result
    send_item(enable_item(2'd2, '0));
    send_item(enable_item(2'd1, 64'hAAAA_AAAA_AAAA_AAAA));
    send_item(query_item(QCOL, 8'd0, 1'b1, 1'b1));

    // Enables written mid-query apply to that query's result
    send_item(query_item(QCOL, 8'd128, 1'b0, 1'b0));
    send_item(enable_item(2'd0, 64'h5555_5555_5555_5555));
    send_item(query_item(QCOL, 8'd128, 1'b0, 1'b1));
    for (int w = 0; w < 3; w++)
      send_item(enable_item(EIDX_W'(w), '1));

    // Random traffic; the receiver's long hold-off starts with it
    hold_request = 1'b1;
    random_start = items_accepted;
    while (items_accepted < random_start + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          case ($urandom_range(0, 19))
            0:          ncols = COLUMNS;
            1, 2, 3:    ncols = $urandom_range(5, 12);
            default:    ncols = $urandom_range(1, 4);
          endcase
          send_query(ncols);
        end
        10, 11, 12:
          send_item(enable_item(EIDX_W'($urandom), random_mask()));
        13: begin
          // stray operation code, ignored by the block
          cam_item_t junk;
          junk    = noise_item();
          junk.op = OP_UNUSED;
          send_item(junk);
        end
        default:
          send_item(random_program($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1)));
      endcase
    end
    // Close any query left open so its words are flushed too
    send_item(query_item(QCOL, BOUND_W'($urandom), 1'b1, 1'b1));
    in_valid_i <= 1'b0;

    while (shadow.match_words_due.size() != 0) @(posedge clk_i);
    // Anything arriving now is an extra word and gets flagged by the receiver
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (shadow.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
